### hdl/agas_pkg.sv
// shared types, constants and helpers for the affine gap alignment scorer
package agas_pkg;

    localparam int SYMBOL_COUNT_DEF = 128;
    localparam int ACC_WIDTH_DEF    = 40;
    localparam int SYM_W            = 7;
    localparam int SCORE_W          = 8;
    localparam int PEN_W            = 12;
    localparam int DELTA_W          = 13;
    localparam int OUT_W            = 40;
    localparam int CFG_IDX_W        = 1;

    localparam logic [SYM_W-1:0] GAP_SYM = 7'd45;

    localparam logic FUNC_TABLE_WRITE = 1'b0;
    localparam logic FUNC_COLUMN      = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_GAP_OPEN   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_EXTEND = 1'b1;

    localparam logic [PEN_W-1:0] GAP_OPEN_RST   = 12'd160;
    localparam logic [PEN_W-1:0] GAP_EXTEND_RST = 12'd8;

    typedef enum logic [1:0] {
        LEAD_SKIP_FIRST,
        LEAD_SKIP_SECOND,
        LEAD_SCORING
    } t_lead;

    typedef struct packed {
        logic                      func;
        logic [SYM_W-1:0]          sym_first;
        logic [SYM_W-1:0]          sym_second;
        logic signed [SCORE_W-1:0] table_score;
        logic                      last_column;
    } t_in_beat;

    typedef struct packed {
        logic signed [OUT_W-1:0] full_score;
        logic signed [OUT_W-1:0] trimmed_score;
        logic                    trimmed_empty;
    } t_out_beat;

    typedef struct packed {
        logic valid;
        logic gap_first;
        logic gap_second;
        logic hit;
        logic last;
    } t_col_ctl;

    typedef struct packed {
        logic signed [DELTA_W-1:0] delta;
        logic [1:0]                flags;
    } t_col_step;

    // flags bit 0: previous column gap in row one, bit 1: gap in row two
    function automatic t_col_step col_step(
        input logic                      gap_first,
        input logic                      gap_second,
        input logic [1:0]                flags,
        input logic [PEN_W-1:0]          gap_open,
        input logic [PEN_W-1:0]          gap_extend,
        input logic signed [SCORE_W-1:0] tbl,
        input logic                      hit
    );
        t_col_step st;
        if (gap_first) begin
            st.delta = -$signed({1'b0, (flags[0] ? gap_extend : gap_open)});
            st.flags = 2'b01;
        end else if (gap_second) begin
            st.delta = -$signed({1'b0, (flags[1] ? gap_extend : gap_open)});
            st.flags = 2'b10;
        end else begin
            st.delta = hit ? $signed({tbl[SCORE_W-1], tbl, 4'b0000}) : '0;
            st.flags = 2'b00;
        end
        return st;
    endfunction

endpackage

### hdl/agas_table.sv
// substitution table memory, one write and one registered read port
module agas_table import agas_pkg::*; #(
    parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF,
    parameter int ADDR_W       = $clog2(SYMBOL_COUNT * SYMBOL_COUNT)
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [ADDR_W-1:0]         i_waddr,
    input  logic signed [SCORE_W-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [ADDR_W-1:0]         i_raddr,
    output logic signed [SCORE_W-1:0] o_rdata
);

    localparam int DEPTH = SYMBOL_COUNT * SYMBOL_COUNT;

    logic signed [SCORE_W-1:0] r_mem [DEPTH];
    logic signed [SCORE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/agas_column.sv
// column scoring: full and trimmed accumulators, trimming state, result register
module agas_column import agas_pkg::*; #(
    parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [PEN_W-1:0]          i_gap_open,
    input  logic [PEN_W-1:0]          i_gap_extend,
    input  t_col_ctl                  i_ctl,
    input  logic signed [SCORE_W-1:0] i_tbl,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output t_out_beat                 o_out_beat
);

    logic signed [ACC_WIDTH-1:0] r_full_acc,  n_full_acc;
    logic [1:0]                  r_full_flags, n_full_flags;
    logic signed [ACC_WIDTH-1:0] r_trim_acc,  n_trim_acc;
    logic [1:0]                  r_trim_flags, n_trim_flags;
    t_lead                       r_lead,      n_lead;
    logic signed [ACC_WIDTH-1:0] r_snap,      n_snap;
    logic signed [ACC_WIDTH-1:0] r_end_score, n_end_score;
    logic                        r_end_empty, n_end_empty;
    logic                        r_out_valid, n_out_valid;
    t_out_beat                   r_out,       n_out;

    t_col_step                   full_step;
    t_col_step                   trim_step;
    t_lead                       lead_a;
    t_lead                       lead_b;
    logic signed [ACC_WIDTH-1:0] full_sum;
    logic signed [ACC_WIDTH-1:0] trim_sum;

    function automatic logic signed [ACC_WIDTH-1:0] sat_add(
        input logic signed [ACC_WIDTH-1:0] acc,
        input logic signed [DELTA_W-1:0]   d
    );
        logic signed [ACC_WIDTH:0] s;
        s = (ACC_WIDTH+1)'(acc) + (ACC_WIDTH+1)'(d);
        if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
            return s[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                : {1'b0, {(ACC_WIDTH-1){1'b1}}};
        end
        return s[ACC_WIDTH-1:0];
    endfunction

    function automatic logic signed [OUT_W-1:0] to_out(
        input logic signed [ACC_WIDTH-1:0] acc
    );
        logic signed [63:0] w;
        w = 64'(acc);
        return w[OUT_W-1:0];
    endfunction

    always_comb begin
        n_full_acc   = r_full_acc;
        n_full_flags = r_full_flags;
        n_trim_acc   = r_trim_acc;
        n_trim_flags = r_trim_flags;
        n_lead       = r_lead;
        n_snap       = r_snap;
        n_end_score  = r_end_score;
        n_end_empty  = r_end_empty;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;

        full_step = col_step(i_ctl.gap_first, i_ctl.gap_second, r_full_flags,
                             i_gap_open, i_gap_extend, i_tbl, i_ctl.hit);
        trim_step = col_step(i_ctl.gap_first, i_ctl.gap_second, r_trim_flags,
                             i_gap_open, i_gap_extend, i_tbl, i_ctl.hit);
        full_sum  = sat_add(r_full_acc, full_step.delta);
        trim_sum  = sat_add(r_trim_acc, trim_step.delta);

        lead_a = (r_lead == LEAD_SKIP_FIRST && !i_ctl.gap_first) ? LEAD_SKIP_SECOND : r_lead;
        lead_b = (lead_a == LEAD_SKIP_SECOND && !i_ctl.gap_second) ? LEAD_SCORING : lead_a;

        if (i_ctl.valid) begin
            n_full_acc   = full_sum;
            n_full_flags = full_step.flags;
            n_lead       = lead_b;
            if (lead_b == LEAD_SCORING) begin
                n_trim_acc   = trim_sum;
                n_trim_flags = trim_step.flags;
                if (!i_ctl.gap_second) begin
                    n_snap = trim_sum;
                end
            end
            if (!i_ctl.gap_first) begin
                if (lead_b == LEAD_SCORING) begin
                    n_end_score = n_snap;
                    n_end_empty = 1'b0;
                end else begin
                    n_end_score = '0;
                    n_end_empty = 1'b1;
                end
            end
            if (i_ctl.last) begin
                n_out_valid         = 1'b1;
                n_out.full_score    = to_out(n_full_acc);
                n_out.trimmed_score = n_end_empty ? '0 : to_out(n_end_score);
                n_out.trimmed_empty = n_end_empty;
                // alignment state back to its start
                n_full_acc   = '0;
                n_full_flags = '0;
                n_trim_acc   = '0;
                n_trim_flags = '0;
                n_lead       = LEAD_SKIP_FIRST;
                n_snap       = '0;
                n_end_score  = '0;
                n_end_empty  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_acc   <= '0;
            r_full_flags <= '0;
            r_trim_acc   <= '0;
            r_trim_flags <= '0;
            r_lead       <= LEAD_SKIP_FIRST;
            r_snap       <= '0;
            r_end_score  <= '0;
            r_end_empty  <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            r_full_acc   <= n_full_acc;
            r_full_flags <= n_full_flags;
            r_trim_acc   <= n_trim_acc;
            r_trim_flags <= n_trim_flags;
            r_lead       <= n_lead;
            r_snap       <= n_snap;
            r_end_score  <= n_end_score;
            r_end_empty  <= n_end_empty;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.valid && i_ctl.last |=>
            r_full_acc == '0 && r_lead == LEAD_SKIP_FIRST && r_end_empty && r_out_valid)
        else $error("alignment state not cleared after last column");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.trimmed_empty |-> r_out.trimmed_score == '0)
        else $error("empty trimmed result carries a score");

    a_lead_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lead != LEAD_SCORING |-> r_trim_acc == '0 && r_end_empty)
        else $error("trimmed score moved before leading gaps ended");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.valid && i_ctl.last |-> !r_out_valid || i_out_ready)
        else $error("result register overwritten while pending");

endmodule

### hdl/affine_gap_alignment_scorer.sv
// Affine gap alignment scorer. One beat is accepted per clock: table-write beats write the
// SYMBOL_COUNT x SYMBOL_COUNT substitution memory, column beats read it at accept and are
// scored as they leave the stage register, so columns stream at one per cycle. A result beat
// is formed as the last column is scored and held in an output register; the input only stalls
// when a last column meets a result that has not been taken. The table needs no clearing pass;
// entries must be written before use. Gap penalties must be written only when idle, unchecked.
module affine_gap_alignment_scorer import agas_pkg::*; #(
    parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF,
    parameter int ACC_WIDTH    = ACC_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [PEN_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_beat             i_in_beat,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_beat            o_out_beat
);

    localparam int ADDR_W = $clog2(SYMBOL_COUNT * SYMBOL_COUNT);

    logic [PEN_W-1:0] r_gap_open;
    logic [PEN_W-1:0] r_gap_extend;
    t_col_ctl         r_stage;

    logic                      in_fire;
    logic                      hit;
    logic                      adv;
    logic [ADDR_W-1:0]         addr;
    logic signed [SCORE_W-1:0] tbl;
    t_col_ctl                  col_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_open   <= GAP_OPEN_RST;
            r_gap_extend <= GAP_EXTEND_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GAP_OPEN:   r_gap_open   <= i_cfg_data;
                CFG_GAP_EXTEND: r_gap_extend <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign hit  = (int'(i_in_beat.sym_first) < SYMBOL_COUNT)
               && (int'(i_in_beat.sym_second) < SYMBOL_COUNT);
    assign addr = ADDR_W'(i_in_beat.sym_first) * ADDR_W'(SYMBOL_COUNT)
                + ADDR_W'(i_in_beat.sym_second);

    assign adv        = r_stage.valid && (!r_stage.last || !o_out_valid || i_out_ready);
    assign o_in_ready = !r_stage.valid || adv;
    assign in_fire    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_stage.gap_first  <= (i_in_beat.sym_first == GAP_SYM);
            r_stage.gap_second <= (i_in_beat.sym_second == GAP_SYM);
            r_stage.hit        <= hit;
            r_stage.last       <= i_in_beat.last_column;
        end
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (in_fire) begin
            r_stage.valid <= (i_in_beat.func == FUNC_COLUMN);
        end else if (adv) begin
            r_stage.valid <= 1'b0;
        end
    end

    agas_table #(
        .SYMBOL_COUNT (SYMBOL_COUNT),
        .ADDR_W       (ADDR_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (in_fire && i_in_beat.func == FUNC_TABLE_WRITE && hit),
        .i_waddr (addr),
        .i_wdata (i_in_beat.table_score),
        .i_re    (in_fire && i_in_beat.func == FUNC_COLUMN && hit),
        .i_raddr (addr),
        .o_rdata (tbl)
    );

    always_comb begin
        col_ctl       = r_stage;
        col_ctl.valid = adv;
    end

    agas_column #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_column (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_gap_open   (r_gap_open),
        .i_gap_extend (r_gap_extend),
        .i_ctl        (col_ctl),
        .i_tbl        (tbl),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_out_beat   (o_out_beat)
    );

endmodule

### tb/affine_gap_alignment_scorer_tb.sv
// self-checking testbench for the affine gap alignment scorer: directed table, then random alignments
`timescale 1ns / 100ps

module affine_gap_alignment_scorer_tb;
    import agas_pkg::*;

    localparam int     PHASES       = 8;
    localparam int     PHASE_ITEMS  = 200;
    localparam int     DRAIN_CYCLES = 6;
    localparam int     HOLD_CYCLES  = 400;
    localparam int     HOLD_AFTER   = 40;
    localparam int     CYCLE_LIMIT  = 600000;
    localparam int     NSYM         = SYMBOL_COUNT_DEF;
    localparam longint ACC_HI       = (longint'(1) <<< (ACC_WIDTH_DEF - 1)) - 1;

    localparam logic [SYM_W-1:0] SYM_A  = 7'd65;
    localparam logic [SYM_W-1:0] SYM_C  = 7'd67;
    localparam logic [SYM_W-1:0] SYM_G  = 7'd71;
    localparam logic [SYM_W-1:0] SYM_LO = 7'd0;
    localparam logic [SYM_W-1:0] SYM_HI = 7'd127;

    typedef enum int {COL_MATCH, COL_GAP_FIRST, COL_GAP_SECOND} t_col_kind;

    typedef struct packed {
        t_in_beat  beat;
        logic      typed;
        t_out_beat want;
    } t_dir_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [PEN_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in_beat             i_in_beat;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_out_beat            o_out_beat;

    // scoring model state
    logic signed [SCORE_W-1:0] subst [NSYM][NSYM];
    logic [PEN_W-1:0]          gap_open_cfg   = GAP_OPEN_RST;
    logic [PEN_W-1:0]          gap_extend_cfg = GAP_EXTEND_RST;
    longint                    full_acc;
    logic [1:0]                full_flags;
    longint                    trim_acc;
    logic [1:0]                trim_flags;
    t_lead                     lead_state;
    longint                    snap_second;
    longint                    tail_score;
    logic                      tail_empty;

    t_out_beat            expected_scores [$];
    bit                   pair_seen [NSYM][NSYM];
    logic [2*SYM_W-1:0]   pair_pool [$];
    int                   items_sent;
    int                   results_seen;
    int                   mismatch_count;
    int                   cycle_count;
    bit                   calm;
    bit                   hold_done;

    affine_gap_alignment_scorer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

    always #2 i_clk = ~i_clk;

    function automatic int idle_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic void restart_alignment();
        full_acc    = 0;
        full_flags  = 2'b00;
        trim_acc    = 0;
        trim_flags  = 2'b00;
        lead_state  = LEAD_SKIP_FIRST;
        snap_second = 0;
        tail_score  = 0;
        tail_empty  = 1'b1;
    endfunction

    // flags bit 0: previous column gap in row one, bit 1: gap in row two
    function automatic longint tally_column(input longint acc, inout logic [1:0] flags,
                                            input logic [SYM_W-1:0] c1,
                                            input logic [SYM_W-1:0] c2);
        longint step;
        if (c1 == GAP_SYM) begin
            step  = flags[0] ? gap_extend_cfg : gap_open_cfg;
            step  = -step;
            flags = 2'b01;
        end else if (c2 == GAP_SYM) begin
            step  = flags[1] ? gap_extend_cfg : gap_open_cfg;
            step  = -step;
            flags = 2'b10;
        end else begin
            step  = subst[c1][c2];
            step  = step * 16;
            flags = 2'b00;
        end
        if (acc + step > ACC_HI) return ACC_HI;
        if (acc + step < -ACC_HI - 1) return -ACC_HI - 1;
        return acc + step;
    endfunction

    function automatic bit predict_scores(input t_in_beat b, output t_out_beat r);
        r = '0;
        if (b.func == FUNC_TABLE_WRITE) begin
            subst[b.sym_first][b.sym_second] = b.table_score;
            return 1'b0;
        end
        full_acc = tally_column(full_acc, full_flags, b.sym_first, b.sym_second);
        if (lead_state == LEAD_SKIP_FIRST && b.sym_first != GAP_SYM)
            lead_state = LEAD_SKIP_SECOND;
        if (lead_state == LEAD_SKIP_SECOND && b.sym_second != GAP_SYM)
            lead_state = LEAD_SCORING;
        if (lead_state == LEAD_SCORING) begin
            trim_acc = tally_column(trim_acc, trim_flags, b.sym_first, b.sym_second);
            if (b.sym_second != GAP_SYM) snap_second = trim_acc;
        end
        if (b.sym_first != GAP_SYM) begin
            tail_empty = (lead_state != LEAD_SCORING);
            tail_score = tail_empty ? 0 : snap_second;
        end
        if (!b.last_column) return 1'b0;
        r.full_score    = full_acc[OUT_W-1:0];
        r.trimmed_score = tail_empty ? '0 : tail_score[OUT_W-1:0];
        r.trimmed_empty = tail_empty;
        restart_alignment();
        return 1'b1;
    endfunction

    function automatic t_dir_row dir_row(input logic f, input logic [SYM_W-1:0] s1,
                                         input logic [SYM_W-1:0] s2, input int sc,
                                         input logic last, input logic typed,
                                         input longint full, input longint trim,
                                         input logic empty);
        t_dir_row r;
        r.beat.func               = f;
        r.beat.sym_first          = s1;
        r.beat.sym_second         = s2;
        r.beat.table_score        = sc[SCORE_W-1:0];
        r.beat.last_column        = last;
        r.typed                   = typed;
        r.want.full_score         = full[OUT_W-1:0];
        r.want.trimmed_score      = trim[OUT_W-1:0];
        r.want.trimmed_empty      = empty;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input t_out_beat got,
                                   input t_out_beat want);
        mismatch_count++;
        if (mismatch_count <= 20)
            $display("result %0d %s: got %0d/%0d/%0b want %0d/%0d/%0b", results_seen, what,
                     got.full_score, got.trimmed_score, got.trimmed_empty,
                     want.full_score, want.trimmed_score, want.trimmed_empty);
    endtask

    task automatic drive_beat(input t_in_beat b, input bit typed, input t_out_beat typed_want);
        int        gap;
        t_out_beat want;
        gap = idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (predict_scores(b, want)) expected_scores.push_back(typed ? typed_want : want);
        if (b.func == FUNC_TABLE_WRITE && b.sym_first != GAP_SYM && b.sym_second != GAP_SYM
            && !pair_seen[b.sym_first][b.sym_second]) begin
            pair_seen[b.sym_first][b.sym_second] = 1'b1;
            pair_pool.push_back({b.sym_first, b.sym_second});
        end
        items_sent++;
    endtask

    task automatic send_table_write();
        t_in_beat           b;
        logic [2*SYM_W-1:0] pr;
        b.func = FUNC_TABLE_WRITE;
        if (pair_pool.size() != 0 && $urandom_range(0, 3) == 0) begin
            pr           = pair_pool[$urandom_range(0, pair_pool.size() - 1)];
            b.sym_first  = pr[2*SYM_W-1:SYM_W];
            b.sym_second = pr[SYM_W-1:0];
        end else begin
            b.sym_first  = $urandom_range(0, NSYM - 1);
            b.sym_second = $urandom_range(0, NSYM - 1);
        end
        b.table_score = $urandom_range(0, 255);
        b.last_column = $urandom_range(0, 1);
        drive_beat(b, 1'b0, '0);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_out_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_scores.size() == 0) begin
                report_mismatch("unexpected beat", o_out_beat, '0);
            end else begin
                want = expected_scores.pop_front();
                if (o_out_beat !== want) report_mismatch("wrong fields", o_out_beat, want);
            end
        end
    end

    // result side: random stalls plus one long hold-off so the input backs up
    initial begin : result_sink
        int n;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            n = idle_len();
            if (n > 0) begin
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    initial begin : stimulus
        t_dir_row           dir_rows [$];
        t_in_beat           b;
        t_col_kind          kind;
        t_col_kind          tail_kind;
        logic [2*SYM_W-1:0] pr;
        logic [PEN_W-1:0]   op;
        logic [PEN_W-1:0]   ex;
        int                 phase;
        int                 phase_end;
        int                 i;
        int                 n;
        int                 l1;
        int                 l2;
        int                 nb;
        int                 t1;
        int                 t2;
        bit                 noisy;
        bit                 swap_tail;

        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_GAP_OPEN;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_in_beat      = '0;
        i_out_ready    = 1'b0;
        items_sent     = 0;
        results_seen   = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        calm           = 1'b0;
        hold_done      = 1'b0;
        restart_alignment();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // table extremes, then gap handling, trimming and empty cases under reset penalties
        dir_rows.push_back(dir_row(FUNC_TABLE_WRITE, SYM_A, SYM_A, 127, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(FUNC_TABLE_WRITE, SYM_A, SYM_C, -128, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(FUNC_TABLE_WRITE, SYM_LO, SYM_HI, 1, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(FUNC_TABLE_WRITE, SYM_HI, SYM_LO, -1, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(FUNC_TABLE_WRITE, SYM_HI, SYM_HI, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(FUNC_COLUMN, SYM_A, SYM_A, 0, 1, 1, 2032, 2032, 0));
        dir_rows.push_back(dir_row(FUNC_COLUMN, GAP_SYM, SYM_A, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(FUNC_COLUMN, SYM_A, GAP_SYM, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(FUNC_COLUMN, SYM_A, SYM_C, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(FUNC_COLUMN, GAP_SYM, SYM_A, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(FUNC_COLUMN, GAP_SYM, SYM_A, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(FUNC_COLUMN, SYM_A, GAP_SYM, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(FUNC_COLUMN, SYM_A, GAP_SYM, 0, 1, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(FUNC_COLUMN, GAP_SYM, GAP_SYM, 0, 1, 1, -160, 0, 1));
        dir_rows.push_back(dir_row(FUNC_COLUMN, SYM_A, GAP_SYM, 0, 1, 1, -160, 0, 1));
        dir_rows.push_back(dir_row(FUNC_TABLE_WRITE, GAP_SYM, GAP_SYM, -128, 1, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(FUNC_COLUMN, SYM_LO, SYM_HI, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(FUNC_COLUMN, SYM_HI, SYM_LO, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(FUNC_COLUMN, SYM_HI, SYM_HI, 0, 1, 1, 0, 0, 0));
        dir_rows.push_back(dir_row(FUNC_TABLE_WRITE, SYM_G, SYM_G, 3, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(FUNC_COLUMN, SYM_G, SYM_G, 0, 1, 1, 48, 48, 0));
        dir_rows.push_back(dir_row(FUNC_COLUMN, SYM_A, SYM_C, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(dir_row(FUNC_COLUMN, SYM_A, SYM_C, 0, 1, 1, -4096, -4096, 0));

        foreach (dir_rows[k])
            drive_beat(dir_rows[k].beat, dir_rows[k].typed, dir_rows[k].want);

        for (phase = 0; phase < PHASES; phase++) begin
            i_in_valid <= 1'b0;
            while (expected_scores.size() != 0) @(posedge i_clk);
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            case (phase)
                0: begin op = '0;  ex = '0;  end
                1: begin op = '1;  ex = '1;  end
                2: begin op = '0;  ex = '1;  end
                3: begin op = '1;  ex = '0;  end
                default: begin
                    op = $urandom_range(0, 4095);
                    ex = $urandom_range(0, 4095);
                end
            endcase
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_GAP_OPEN;
            i_cfg_data <= op;
            @(posedge i_clk);
            i_cfg_idx  <= CFG_GAP_EXTEND;
            i_cfg_data <= ex;
            @(posedge i_clk);
            i_cfg_we   <= 1'b0;
            gap_open_cfg   = op;
            gap_extend_cfg = ex;
            calm = (phase % 3 == 1);

            repeat (6) send_table_write();
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                noisy     = ($urandom_range(0, 9) == 0);
                swap_tail = $urandom_range(0, 1);
                l1 = $urandom_range(0, 3);
                l2 = $urandom_range(0, 3);
                nb = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 10);
                t1 = $urandom_range(0, 3);
                t2 = $urandom_range(0, 3);
                n  = noisy ? $urandom_range(1, 12) : l1 + l2 + nb + t1 + t2;
                for (i = 0; i < n; i++) begin
                    if (noisy) kind = t_col_kind'($urandom_range(0, 2));
                    else if (i < l1) kind = COL_GAP_FIRST;
                    else if (i < l1 + l2) kind = COL_GAP_SECOND;
                    else if (i < l1 + l2 + nb) begin
                        case ($urandom_range(0, 9))
                            7, 8:    kind = COL_GAP_FIRST;
                            9:       kind = COL_GAP_SECOND;
                            default: kind = COL_MATCH;
                        endcase
                    end else begin
                        tail_kind = swap_tail ? COL_GAP_SECOND : COL_GAP_FIRST;
                        if (i < l1 + l2 + nb + t1) kind = tail_kind;
                        else kind = swap_tail ? COL_GAP_FIRST : COL_GAP_SECOND;
                    end
                    if ($urandom_range(0, 19) == 0) send_table_write();
                    b.func        = FUNC_COLUMN;
                    b.table_score = $urandom_range(0, 255);
                    b.last_column = (i == n - 1);
                    case (kind)
                        COL_GAP_FIRST: begin
                            b.sym_first  = GAP_SYM;
                            b.sym_second = $urandom_range(0, NSYM - 1);
                        end
                        COL_GAP_SECOND: begin
                            do b.sym_first = $urandom_range(0, NSYM - 1);
                            while (b.sym_first == GAP_SYM);
                            b.sym_second = GAP_SYM;
                        end
                        default: begin
                            pr           = pair_pool[$urandom_range(0, pair_pool.size() - 1)];
                            b.sym_first  = pr[2*SYM_W-1:SYM_W];
                            b.sym_second = pr[SYM_W-1:0];
                        end
                    endcase
                    drive_beat(b, 1'b0, '0);
                end
            end
        end

        i_in_valid <= 1'b0;
        while (expected_scores.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
